[src/atd_pkg.sv]
// Shared types and constants for the AT response deframer.
package atd_pkg;

  // Widths fixed by the item fields
  localparam int unsigned ByteW = 8;
  localparam int unsigned LinkW = 4;
  localparam int unsigned LenW  = 11;
  localparam int unsigned EvW   = 2;

  // Match strings
  localparam logic [ByteW-1:0] TXT_OK [2]     = '{8'h4F, 8'h4B};
  localparam logic [ByteW-1:0] TXT_FAILED [6] = '{8'h46, 8'h61, 8'h69, 8'h6C, 8'h65, 8'h64};
  localparam logic [ByteW-1:0] TXT_IPD [5]    = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};
  localparam int unsigned      OkLen     = 2;
  localparam int unsigned      FailedLen = 6;
  localparam int unsigned      IpdLen    = 5;

  localparam logic [ByteW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CHAR_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_COLON = 8'h3A;
  localparam logic [ByteW-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [ByteW-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [ByteW-1:0] CHAR_NINE  = 8'h39;

  localparam logic [LenW-1:0]  MAX_PAYLOAD_RST = 11'd1024;
  localparam logic [LenW-1:0]  LEN_SAT         = 11'd2047;
  localparam logic [LinkW-1:0] LINK_SAT        = 4'd15;

  // Result codes
  typedef enum logic [EvW-1:0] {
    EV_REPLY    = 2'd0,
    EV_DATA     = 2'd1,
    EV_OVERFLOW = 2'd2,
    EV_TOO_LONG = 2'd3
  } event_e;

  // Parser mode, one-hot
  typedef enum logic [3:0] {
    MODE_LINE = 4'b0001,
    MODE_LINK = 4'b0010,
    MODE_LEN  = 4'b0100,
    MODE_DATA = 4'b1000
  } mode_e;

  // Classified byte handed from front to back
  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             awaiting_reply;
    logic             eol;
    logic             digit;
    logic [3:0]       dval;
    logic             comma;
    logic             colon;
    logic [1:0]       ok_hit;
    logic [7:0]       fail_hit;
    logic [7:0]       ipd_hit;
  } class_t;

endpackage

[src/atd_chan_if.sv]
// Valid/ready channel interfaces for received bytes and result events.
interface atd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       awaiting_reply;

  modport source (output valid, rx_byte, awaiting_reply, input ready);
  modport sink   (input valid, rx_byte, awaiting_reply, output ready);
endinterface

interface atd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       reply_failed;
  logic [7:0] data_byte;
  logic [3:0] link_id;
  logic       payload_last;

  modport source (output valid, event_res, reply_failed, data_byte, link_id, payload_last,
                  input ready);
  modport sink   (input valid, event_res, reply_failed, data_byte, link_id, payload_last,
                  output ready);
endinterface

[src/atd_classify.sv]
// Front end: accepts received bytes and classifies each character.
module atd_classify (
  atd_in_if.sink          in_ch,
  output logic            cls_valid_o,
  input  logic            cls_ready_i,
  output atd_pkg::class_t cls_o
);
  import atd_pkg::*;

  assign cls_valid_o = in_ch.valid;
  assign in_ch.ready = cls_ready_i;

  // Character classes and per-position string hits
  always_comb begin
    cls_o                = '0;
    cls_o.rx_byte        = in_ch.rx_byte;
    cls_o.awaiting_reply = in_ch.awaiting_reply;
    cls_o.eol            = (in_ch.rx_byte == CHAR_CR) || (in_ch.rx_byte == CHAR_LF);
    cls_o.digit          = (in_ch.rx_byte >= CHAR_ZERO) && (in_ch.rx_byte <= CHAR_NINE);
    cls_o.dval           = 4'(in_ch.rx_byte - CHAR_ZERO);
    cls_o.comma          = (in_ch.rx_byte == CHAR_COMMA);
    cls_o.colon          = (in_ch.rx_byte == CHAR_COLON);
    for (int i = 0; i < OkLen; i++) begin
      cls_o.ok_hit[i] = (in_ch.rx_byte == TXT_OK[i]);
    end
    for (int i = 0; i < FailedLen; i++) begin
      cls_o.fail_hit[i] = (in_ch.rx_byte == TXT_FAILED[i]);
    end
    for (int i = 0; i < IpdLen; i++) begin
      cls_o.ipd_hit[i] = (in_ch.rx_byte == TXT_IPD[i]);
    end
  end

endmodule

[src/atd_queue.sv]
// Two-entry queue of classified bytes between front and back.
module atd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  atd_pkg::class_t wr_data_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output atd_pkg::class_t rd_data_o
);
  import atd_pkg::*;

  class_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[src/atd_exec.sv]
// Back end: line/header/payload state machine and result register.
module atd_exec #(
  parameter int unsigned LINE_LIMIT = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [10:0]     cfg_wdata_i,
  input  logic            cls_valid_i,
  output logic            cls_ready_o,
  input  atd_pkg::class_t cls_i,
  atd_out_if.source       out_ch
);
  import atd_pkg::*;

  localparam int unsigned    PosW     = $clog2(LINE_LIMIT);
  localparam logic [PosW-1:0] POS_FULL = PosW'(LINE_LIMIT - 1);
  localparam logic [PosW-1:0] POS_OK   = PosW'(OkLen);
  localparam logic [PosW-1:0] POS_FAIL = PosW'(FailedLen);
  localparam logic [PosW-1:0] POS_IPD  = PosW'(IpdLen);

  mode_e            mode_q, mode_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [2:0]       pm_q, pm_d;
  logic [LinkW-1:0] link_q, link_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [LenW-1:0]  rem_q, rem_d;
  logic [LenW-1:0]  max_q;

  logic             take, emit;
  event_e           ev;
  logic             ev_failed, ev_last;
  logic [ByteW-1:0] ev_data;
  logic [LinkW-1:0] ev_link;
  logic [2:0]       hit;
  logic [PosW-1:0]  pos_inc;
  logic [7:0]       link_mul;
  logic [14:0]      len_mul;

  logic             out_valid_q;
  logic [EvW-1:0]   ev_q;
  logic             failed_q, last_q;
  logic [ByteW-1:0] data_q;
  logic [LinkW-1:0] link_out_q;

  // Take a byte when the result register is free or being drained
  assign take        = cls_valid_i && (!out_valid_q || out_ch.ready);
  assign cls_ready_o = !out_valid_q || out_ch.ready;

  // Which candidate strings still match at the current position
  assign hit[0]   = (pos_q < POS_OK)   && cls_i.ok_hit[pos_q[0]];
  assign hit[1]   = (pos_q < POS_FAIL) && cls_i.fail_hit[pos_q[2:0]];
  assign hit[2]   = (pos_q < POS_IPD)  && cls_i.ipd_hit[pos_q[2:0]];
  assign pos_inc  = pos_q + PosW'(1);
  assign link_mul = {1'b0, link_q, 3'b000} + {3'b000, link_q, 1'b0} + {4'b0000, cls_i.dval};
  assign len_mul  = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {11'd0, cls_i.dval};

  // Next state and result
  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    pm_d      = pm_q;
    link_d    = link_q;
    len_d     = len_q;
    rem_d     = rem_q;
    emit      = 1'b0;
    ev        = EV_REPLY;
    ev_failed = 1'b0;
    ev_data   = '0;
    ev_link   = '0;
    ev_last   = 1'b0;
    unique case (mode_q)
      MODE_DATA: begin
        emit    = 1'b1;
        ev      = EV_DATA;
        ev_data = cls_i.rx_byte;
        ev_link = link_q;
        ev_last = (rem_q <= 11'd1);
        if (ev_last) begin
          rem_d  = '0;
          mode_d = MODE_LINE;
          pos_d  = '0;
          pm_d   = 3'b111;
        end else begin
          rem_d = rem_q - 11'd1;
        end
      end
      MODE_LINK, MODE_LEN: begin
        priority if (cls_i.eol) begin
          mode_d = MODE_LINE;
          pos_d  = '0;
          pm_d   = 3'b111;
        end else if (cls_i.digit) begin
          if (mode_q == MODE_LINK) begin
            link_d = (link_mul > 8'(LINK_SAT)) ? LINK_SAT : link_mul[LinkW-1:0];
          end else begin
            len_d = (len_mul > 15'(LEN_SAT)) ? LEN_SAT : len_mul[LenW-1:0];
          end
        end else if (cls_i.comma) begin
          mode_d = MODE_LEN;
        end else if (cls_i.colon) begin
          mode_d = MODE_LINE;
          pos_d  = '0;
          pm_d   = 3'b111;
          if (len_q > max_q) begin
            emit    = 1'b1;
            ev      = EV_TOO_LONG;
            ev_link = link_q;
          end else if (len_q != '0) begin
            rem_d  = len_q;
            mode_d = MODE_DATA;
          end
        end else begin
          mode_d = mode_q;
        end
      end
      default: begin
        priority if (pos_q >= POS_FULL) begin
          pos_d = '0;
          pm_d  = 3'b111;
          emit  = 1'b1;
          ev    = EV_OVERFLOW;
        end else if (cls_i.eol) begin
          pos_d = '0;
          pm_d  = 3'b111;
          if ((pos_q != '0) && cls_i.awaiting_reply) begin
            if (pm_q[0] && (pos_q == POS_OK)) begin
              emit = 1'b1;
              ev   = EV_REPLY;
            end else if (pm_q[1] && (pos_q == POS_FAIL)) begin
              emit      = 1'b1;
              ev        = EV_REPLY;
              ev_failed = 1'b1;
            end
          end
        end else begin
          pm_d  = pm_q & hit;
          pos_d = pos_inc;
          if ((pos_inc == POS_IPD) && pm_d[2]) begin
            pos_d  = '0;
            pm_d   = 3'b111;
            mode_d = MODE_LINK;
            link_d = '0;
            len_d  = '0;
          end
        end
      end
    endcase
  end

  // Parser state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LINE;
      pos_q  <= '0;
      pm_q   <= 3'b111;
      link_q <= '0;
      len_q  <= '0;
      rem_q  <= '0;
      max_q  <= MAX_PAYLOAD_RST;
    end else begin
      if (take) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        pm_q   <= pm_d;
        link_q <= link_d;
        len_q  <= len_d;
        rem_q  <= rem_d;
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      ev_q       <= ev;
      failed_q   <= ev_failed;
      data_q     <= ev_data;
      link_out_q <= ev_link;
      last_q     <= ev_last;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.event_res    = ev_q;
  assign out_ch.reply_failed = failed_q;
  assign out_ch.data_byte    = data_q;
  assign out_ch.link_id      = link_out_q;
  assign out_ch.payload_last = last_q;

endmodule

[src/at_response_ipd_deframer.sv]
// Top level of the AT response deframer with +IPD payload extraction.
//
//   channel  dir  payload                                               handshake
//   in_ch    in   rx_byte, awaiting_reply                               valid/ready
//   out_ch   out  event_res, reply_failed, data_byte, link_id,         valid/ready
//                 payload_last
//   cfg      in   cfg_wdata_i = max_payload                             cfg_we_i
//
// One byte per cycle sustained while the receiver takes each event; a byte is
// written into the queue on its transfer, and its event is then registered in the
// result register. A two-entry queue parts front and back, and the result register
// holds one event; the next byte is taken only while it is empty or being drained.
// Reset clears the parser to line mode and max_payload to 1024.
module at_response_ipd_deframer #(
  parameter int unsigned LINE_LIMIT = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atd_in_if.sink      in_ch,
  atd_out_if.source   out_ch,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);
  import atd_pkg::*;

  logic   f_valid, f_ready;
  class_t f_data;
  logic   b_valid, b_ready;
  class_t b_data;

  atd_classify u_classify (
    .in_ch       (in_ch),
    .cls_valid_o (f_valid),
    .cls_ready_i (f_ready),
    .cls_o       (f_data)
  );

  atd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_data),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_data)
  );

  atd_exec #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cls_valid_i (b_valid),
    .cls_ready_o (b_ready),
    .cls_i       (b_data),
    .out_ch      (out_ch)
  );

endmodule

[test/at_response_ipd_deframer_test.sv]
// Self-checking testbench for the AT response deframer: directed rows, then random traffic.
module at_response_ipd_deframer_test;
  import atd_pkg::*;

  localparam int LineLimit = 128;

  // One result item as it leaves the block
  typedef struct packed {
    event_e           ev;
    logic             failed;
    logic [ByteW-1:0] data;
    logic [LinkW-1:0] link;
    logic             last;
  } deframer_evt_t;

  // One received byte; fixed rows carry a hand-written expectation
  typedef struct {
    logic [ByteW-1:0] b;
    logic             aw;
    bit               fixed;
    bit               has;
    deframer_evt_t    exp;
  } rx_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [LenW-1:0] cfg_wdata;

  atd_in_if  in_ch ();
  atd_out_if out_ch ();

  at_response_ipd_deframer #(
    .LINE_LIMIT(LineLimit)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we_i(cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser copy kept by the testbench
  mode_e            p_mode;
  int               p_pos;
  logic [2:0]       p_match;
  logic [LinkW-1:0] p_link;
  logic [LenW-1:0]  p_len;
  logic [LenW-1:0]  p_left;
  logic [LenW-1:0]  p_max;

  deframer_evt_t pending_events [$];
  rx_item_t      byte_q [$];
  rx_item_t      cur_item;
  int            mismatch_count = 0;
  int            cur_max;
  int            burst_left = 0;
  int            gap_pct = 0;
  int            stall_mode = 0;
  bit            hold_off = 1'b0;
  int            cfg_plan [5];

  function automatic void clear_line();
    p_pos   = 0;
    p_match = '1;
  endfunction

  // Advance the parser copy by one byte; returns 1 when an event comes out
  function automatic bit parse_byte(input logic [ByteW-1:0] c, input logic aw,
                                    output deframer_evt_t r);
    bit eol;
    int v;
    int pos;
    logic [2:0] hits;
    r   = '0;
    eol = (c == CHAR_CR) || (c == CHAR_LF);
    // payload bytes pass straight through
    if (p_mode == MODE_DATA) begin
      r = '{EV_DATA, 1'b0, c, p_link, p_left <= 11'd1};
      if (p_left <= 11'd1) begin
        p_left = '0;
        p_mode = MODE_LINE;
        clear_line();
      end else begin
        p_left--;
      end
      return 1'b1;
    end
    // header: link id, comma, length, colon
    if (p_mode == MODE_LINK || p_mode == MODE_LEN) begin
      if (eol) begin
        p_mode = MODE_LINE;
        clear_line();
        return 1'b0;
      end
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        if (p_mode == MODE_LINK) begin
          v = int'(p_link) * 10 + int'(c - CHAR_ZERO);
          p_link = (v > int'(LINK_SAT)) ? LINK_SAT : LinkW'(v);
        end else begin
          v = int'(p_len) * 10 + int'(c - CHAR_ZERO);
          p_len = (v > int'(LEN_SAT)) ? LEN_SAT : LenW'(v);
        end
        return 1'b0;
      end
      if (c == CHAR_COMMA) begin
        if (p_mode == MODE_LINK) p_mode = MODE_LEN;
        return 1'b0;
      end
      if (c == CHAR_COLON) begin
        p_mode = MODE_LINE;
        clear_line();
        if (p_len > p_max) begin
          r = '{EV_TOO_LONG, 1'b0, 8'h00, p_link, 1'b0};
          return 1'b1;
        end
        if (p_len != '0) begin
          p_left = p_len;
          p_mode = MODE_DATA;
        end
      end
      return 1'b0;
    end
    // line mode: full line drops the byte
    if (p_pos >= LineLimit - 1) begin
      clear_line();
      r = '{EV_OVERFLOW, 1'b0, 8'h00, 4'h0, 1'b0};
      return 1'b1;
    end
    if (eol) begin
      pos  = p_pos;
      hits = p_match;
      clear_line();
      if (pos > 0 && aw) begin
        if (hits[0] && pos == OkLen) begin
          r = '{EV_REPLY, 1'b0, 8'h00, 4'h0, 1'b0};
          return 1'b1;
        end
        if (hits[1] && pos == FailedLen) begin
          r = '{EV_REPLY, 1'b1, 8'h00, 4'h0, 1'b0};
          return 1'b1;
        end
      end
      return 1'b0;
    end
    if (!(p_pos < OkLen && c == TXT_OK[p_pos])) p_match[0] = 1'b0;
    if (!(p_pos < FailedLen && c == TXT_FAILED[p_pos])) p_match[1] = 1'b0;
    if (!(p_pos < IpdLen && c == TXT_IPD[p_pos])) p_match[2] = 1'b0;
    p_pos++;
    if (p_pos == IpdLen && p_match[2]) begin
      clear_line();
      p_mode = MODE_LINK;
      p_link = '0;
      p_len  = '0;
    end
    return 1'b0;
  endfunction

  // Stimulus builders
  function automatic void push_byte(input logic [ByteW-1:0] b, input logic aw);
    byte_q.push_back('{b, aw, 1'b0, 1'b0, '0});
  endfunction

  function automatic void push_fixed(input logic [ByteW-1:0] b, input logic aw, input bit has,
                                     input deframer_evt_t exp);
    byte_q.push_back('{b, aw, 1'b1, has, exp});
  endfunction

  function automatic void push_text(input string s, input logic aw);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], aw);
  endfunction

  function automatic void push_num(input int n, input logic aw);
    push_text($sformatf("%0d", n), aw);
  endfunction

  // +IPD frame; force_len >= 0 picks the length
  function automatic void gen_frame(input int force_len);
    int link_v;
    int len_v;
    int eff;
    int r;
    logic aw;
    aw = 1'($urandom_range(0, 1));
    push_text("+IPD,", aw);
    r = $urandom_range(0, 99);
    link_v = (r < 75) ? $urandom_range(0, 9) :
             (r < 92) ? $urandom_range(10, 15) : $urandom_range(16, 9999);
    if ($urandom_range(0, 19) != 0) push_num(link_v, aw);
    if ($urandom_range(0, 9) == 0) push_text(" x", aw);
    push_byte(CHAR_COMMA, aw);
    if ($urandom_range(0, 9) == 0) push_byte(CHAR_COMMA, aw);
    r = $urandom_range(0, 99);
    if (force_len >= 0) len_v = force_len;
    else if (r < 6) len_v = 0;
    else if (r < 14 && cur_max < int'(LEN_SAT)) len_v = $urandom_range(cur_max + 1, 2047);
    else if (r < 16 && cur_max < int'(LEN_SAT)) len_v = 99999;
    else if (r < 19) len_v = $urandom_range(40, 200);
    else len_v = $urandom_range(1, 12);
    push_num(len_v, aw);
    // line end abandons the header
    if ($urandom_range(0, 19) == 0) begin
      push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, aw);
      return;
    end
    push_byte(CHAR_COLON, aw);
    eff = (len_v > int'(LEN_SAT)) ? int'(LEN_SAT) : len_v;
    if (eff != 0 && eff <= cur_max)
      repeat (eff) push_byte($urandom_range(0, 255), 1'($urandom_range(0, 1)));
  endfunction

  // OK / Failed line, sometimes damaged
  function automatic void gen_reply();
    string s;
    logic aw;
    aw = ($urandom_range(0, 4) != 0);
    s = $urandom_range(0, 1) ? "OK" : "Failed";
    case ($urandom_range(0, 9))
      0: s = s.substr(0, s.len() - 2);
      1: s = {s, "!"};
      2: s = {"x", s};
      default: ;
    endcase
    push_text(s, aw);
    push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, aw);
  endfunction

  // Random traffic mix for one phase
  function automatic void gen_any();
    int r;
    int n;
    logic aw;
    r  = $urandom_range(0, 99);
    aw = 1'($urandom_range(0, 1));
    if (r < 40) gen_frame(-1);
    else if (r < 65) gen_reply();
    else if (r < 69) begin
      // line past the limit
      n = $urandom_range(LineLimit - 4, LineLimit + 12);
      repeat (n) push_byte($urandom_range(8'h41, 8'h5A), aw);
      push_byte(CHAR_CR, aw);
    end else if (r < 85) begin
      n = $urandom_range(1, 6);
      repeat (n) push_byte($urandom_range(0, 255), 1'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, aw);
    end
  endfunction

  // Offer one byte in bursts with random gaps; called and returns at a falling edge
  task automatic send_byte(input rx_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    cur_item = it;
    in_ch.valid          <= 1'b1;
    in_ch.rx_byte        <= it.b;
    in_ch.awaiting_reply <= it.aw;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_all();
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
  endtask

  // Stop offering, let every expected event arrive, then let the pipe settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_max(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= LenW'(v);
    p_max   = LenW'(v);
    cur_max = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // Receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int tick;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        tick++;
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 2) != 0);
          2: out_ch.ready <= ((tick % 5) >= 2);
          default: out_ch.ready <= ($urandom_range(0, 9) < 2);
        endcase
      end
    end
  end

  // Monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin : monitor
    deframer_evt_t pred;
    deframer_evt_t want;
    deframer_evt_t got;
    bit fires;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        fires = parse_byte(in_ch.rx_byte, in_ch.awaiting_reply, pred);
        if (cur_item.fixed) begin
          if (cur_item.has) pending_events.push_back(cur_item.exp);
        end else if (fires) begin
          pending_events.push_back(pred);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{event_e'(out_ch.event_res), out_ch.reply_failed, out_ch.data_byte,
                out_ch.link_id, out_ch.payload_last};
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got ev=%0d data=%0d link=%0d",
                   $time, got.ev, got.data, got.link);
          mismatch_count++;
        end else begin
          want = pending_events.pop_front();
          if (got.ev !== want.ev) report_field("event_res", want.ev, got.ev);
          if (got.failed !== want.failed) report_field("reply_failed", want.failed, got.failed);
          if (got.data !== want.data) report_field("data_byte", want.data, got.data);
          if (got.link !== want.link) report_field("link_id", want.link, got.link);
          if (got.last !== want.last) report_field("payload_last", want.last, got.last);
        end
      end
    end
  end

  // Main sequence
  initial begin
    int sent;
    in_ch.valid          = 1'b0;
    in_ch.rx_byte        = '0;
    in_ch.awaiting_reply = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    p_mode = MODE_LINE;
    clear_line();
    p_link  = '0;
    p_len   = '0;
    p_left  = '0;
    p_max   = MAX_PAYLOAD_RST;
    cur_max = int'(MAX_PAYLOAD_RST);
    cfg_plan = '{1024, 0, 2047, 1, 1024};
    cfg_plan[3] = $urandom_range(1, 40);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < 5; p++) begin
      // first phase runs on the reset value of max_payload
      if (p > 0) write_max(cfg_plan[p]);
      stall_mode = p % 4;
      gap_pct    = (p == 0) ? 0 : 15 * p;
      if (p == 0) begin
        // directed rows: replies, no reply awaited, empty line, saturated link id
        push_text("OK", 1'b1);
        push_fixed(CHAR_CR, 1'b1, 1'b1, '{EV_REPLY, 1'b0, 8'h00, 4'h0, 1'b0});
        push_text("Failed", 1'b1);
        push_fixed(CHAR_LF, 1'b1, 1'b1, '{EV_REPLY, 1'b1, 8'h00, 4'h0, 1'b0});
        push_text("OK", 1'b0);
        push_fixed(CHAR_CR, 1'b0, 1'b0, '0);
        push_fixed(CHAR_LF, 1'b1, 1'b0, '0);
        push_text("+IPD,99,1:", 1'b1);
        push_fixed(8'hFF, 1'b1, 1'b1, '{EV_DATA, 1'b0, 8'hFF, LINK_SAT, 1'b1});
        send_all();
      end
      if (p == 2) begin
        // long receiver hold-off while a payload keeps coming
        hold_off = 1'b1;
        gen_frame(60);
        send_all();
      end
      sent = 0;
      while (sent < 120) begin
        gen_any();
        sent += byte_q.size();
        send_all();
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
